// ===== src/ts_psi_section_reassembler_unit_macros.svh =====
// Assertion helpers for the section reassembler
`ifndef TS_PSI_SECTION_REASSEMBLER_UNIT_MACROS_SVH
`define TS_PSI_SECTION_REASSEMBLER_UNIT_MACROS_SVH

// Implication checked on every clock, off during reset
`define TSR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication
`define TSR_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/tsr_pkg.sv =====
package tsr_pkg;
  localparam int PacketBytesDef = 188;
  localparam int SlotCountDef   = 3;
  localparam int HeaderBytes    = 3;

  localparam logic [7:0]  SyncValue  = 8'h47;
  localparam logic [7:0]  StuffValue = 8'hFF;
  localparam logic [31:0] CrcPoly    = 32'h04C11DB7;
  localparam logic [7:0]  NoPayload  = 8'd255;

  localparam logic [1:0] CfgSlot0Pid = 2'd0;
  localparam logic [1:0] CfgSlot1Pid = 2'd1;
  localparam logic [1:0] CfgSlot2Pid = 2'd2;
  localparam logic [1:0] CfgSlotEn   = 2'd3;

  typedef enum logic [2:0] {
    StInProgress = 3'd0,
    StCrcGood    = 3'd1,
    StCrcBad     = 3'd2,
    StTooShort   = 3'd3,
    StSyncError  = 3'd4
  } status_e;

  // classified byte handed from front to back
  typedef struct packed {
    logic [7:0] data;
    logic [1:0] slot;
    logic       sync_err;
    logic       tail;      // inside pointer tail segment
    logic       tail_end;  // last byte of pointer tail
    logic       seg_clr;   // new packet or pointer seen since the previous byte
  } work_t;

  function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {b, 24'h0};
    for (int k = 0; k < 8; k++) begin
      c = c[31] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction
endpackage

// ===== src/tsr_front.sv =====
module tsr_front import tsr_pkg::*; #(
  parameter int PacketBytes = PacketBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  ts_byte_i,
  input  logic [12:0] pid0_i,
  input  logic [12:0] pid1_i,
  input  logic [12:0] pid2_i,
  input  logic [2:0]  en_i,
  output logic        wr_o,
  output work_t       wdata_o,
  input  logic        qfull_i
);
  logic [7:0]  pos_q, pos_d;
  logic [15:0] hdr_q, hdr_d;
  logic [7:0]  pso_q, pso_d;
  logic [7:0]  ptr_q, ptr_d;
  logic        halt_q, halt_d;
  logic        clr_q, clr_d;
  logic        acc;
  logic [12:0] pid;
  logic [1:0]  slot;
  logic        hit;
  logic [8:0]  v;

  assign full = qfull_i | halt_q;
  assign acc  = push & ~full;
  assign pid  = hdr_q[12:0];
  assign v    = 9'd5 + {1'b0, ts_byte_i};

  always_comb begin
    hit  = 1'b1;
    slot = 2'd0;
    if (en_i[0] && pid0_i == pid) slot = 2'd0;
    else if (en_i[1] && pid1_i == pid) slot = 2'd1;
    else if (en_i[2] && pid2_i == pid) slot = 2'd2;
    else hit = 1'b0;
  end

  always_comb begin
    pos_d = pos_q; hdr_d = hdr_q; pso_d = pso_q; ptr_d = ptr_q; halt_d = halt_q;
    clr_d = clr_q;
    wr_o = 1'b0;
    wdata_o = '{data: ts_byte_i, slot: slot, sync_err: 1'b0,
                tail: ptr_q != 8'd0, tail_end: ptr_q == 8'd1, seg_clr: clr_q};
    if (acc) begin
      pos_d = (32'(pos_q) + 1 >= PacketBytes) ? 8'd0 : pos_q + 8'd1;
      if (pos_q == 8'd0) begin
        if (ts_byte_i != SyncValue) begin
          halt_d = 1'b1;
          wr_o = 1'b1;
          wdata_o = '{data: 8'd0, slot: 2'd0, sync_err: 1'b1, tail: 1'b0, tail_end: 1'b0,
                      seg_clr: 1'b0};
        end else begin
          hdr_d = '0; pso_d = NoPayload; ptr_d = '0;
          clr_d = 1'b1;  // segment drop ends with the packet
        end
      end else if (pos_q == 8'd1) begin
        hdr_d = {ts_byte_i, 8'd0};
      end else if (pos_q == 8'd2) begin
        hdr_d = {hdr_q[15:8], ts_byte_i};
      end else if (pos_q == 8'd3) begin
        case (ts_byte_i[5:4])
          2'd1:    pso_d = 8'd4;
          2'd3:    pso_d = 8'd0;
          default: pso_d = NoPayload;
        endcase
      end else if (pos_q == 8'd4 && pso_q == 8'd0) begin
        pso_d = v[8] ? NoPayload : v[7:0];
      end else if (pso_q != 8'd0 && pos_q >= pso_q && hit) begin
        if (hdr_q[14] && pos_q == pso_q) begin
          ptr_d = ts_byte_i;
          clr_d = 1'b1;  // pointer field also ends a segment drop
        end else begin
          wr_o = 1'b1;
          clr_d = 1'b0;
          if (ptr_q != 8'd0) ptr_d = ptr_q - 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0; hdr_q <= '0; pso_q <= '0; ptr_q <= '0; halt_q <= 1'b0;
      clr_q <= 1'b0;
    end else begin
      pos_q <= pos_d; hdr_q <= hdr_d; pso_q <= pso_d; ptr_q <= ptr_d; halt_q <= halt_d;
      clr_q <= clr_d;
    end
  end
endmodule

// ===== src/tsr_fifo.sv =====
module tsr_fifo import tsr_pkg::*; #(
  parameter int Depth = 2
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  wr_i,
  input  work_t wdata_i,
  output logic  full_o,
  input  logic  rd_i,
  output logic  valid_o,
  output work_t rdata_o
);
  localparam int Aw = $clog2(Depth);
  work_t          mem_q [Depth];
  logic [Aw-1:0]  wp_q, rp_q;
  logic [Aw:0]    cnt_q;

  assign full_o  = cnt_q == (Aw+1)'(Depth);
  assign valid_o = cnt_q != '0;
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wp_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (wr_i) wp_q <= (32'(wp_q) == Depth - 1) ? '0 : wp_q + 1'b1;
      if (rd_i) rp_q <= (32'(rp_q) == Depth - 1) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (Aw+1)'(wr_i) - (Aw+1)'(rd_i);
    end
  end
endmodule

// ===== src/tsr_back.sv =====
module tsr_back import tsr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  work_t      work_i,
  output logic       rd_o,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] section_byte_o,
  output logic [1:0] slot_index_o,
  output logic       first_of_section_o,
  output logic       last_of_section_o,
  output logic [2:0] status_o
);
  logic [12:0] cnt_q [SlotCountDef];
  logic [12:0] tot_q [SlotCountDef];
  logic [31:0] crc_q [SlotCountDef];
  logic        drop_q;
  logic        ov_q;
  logic [7:0]  ob_q;
  logic [1:0]  os_q;
  logic        of_q, ol_q;
  status_e     ost_q;

  logic        take, emit;
  logic [1:0]  s;
  logic [12:0] cnt, cnt1, tot_n;
  logic [31:0] crc_n;
  logic        last, drop_n, drop_c;
  status_e     st;

  assign empty = ~ov_q;
  assign rd_o  = valid_i & (~ov_q | pop);
  assign take  = rd_o;
  assign s     = work_i.slot;
  assign cnt   = cnt_q[s];
  assign crc_n = crc_byte(crc_q[s], work_i.data);
  assign cnt1  = cnt + 13'd1;

  always_comb begin
    tot_n  = tot_q[s];
    if (cnt == 13'd1) tot_n = {1'b0, work_i.data[3:0], 8'd0};
    else if (cnt == 13'd2)
      tot_n = {1'b0, tot_q[s][11:0] | {4'd0, work_i.data}} + 13'(HeaderBytes);
    last   = cnt1 >= 13'(HeaderBytes) && cnt1 == tot_n;
    st     = StInProgress;
    drop_c = drop_q & ~work_i.seg_clr;
    drop_n = drop_c;
    if (last) st = (cnt1 < 13'd4) ? StTooShort : ((crc_n == '0) ? StCrcGood : StCrcBad);
    emit   = ~drop_c & ~(cnt == '0 && work_i.data == StuffValue);
    if (emit && last && cnt1 < 13'd4) drop_n = 1'b1;
    if (work_i.tail && work_i.tail_end) drop_n = 1'b0;
    if (work_i.sync_err) emit = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SlotCountDef; i++) begin
        cnt_q[i] <= '0; tot_q[i] <= '0; crc_q[i] <= '1;
      end
      drop_q <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      if (pop && ov_q) ov_q <= 1'b0;
      if (take) begin
        drop_q <= drop_n;
        if (emit) begin
          ov_q <= 1'b1;
          if (!work_i.sync_err) begin
            cnt_q[s] <= last ? '0 : cnt1;
            tot_q[s] <= last ? '0 : tot_n;
            crc_q[s] <= last ? '1 : crc_n;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && emit) begin
      ob_q  <= work_i.data;
      os_q  <= s;
      of_q  <= ~work_i.sync_err & (cnt == '0);
      ol_q  <= ~work_i.sync_err & last;
      ost_q <= work_i.sync_err ? StSyncError : st;
    end
  end

  assign section_byte_o     = ob_q;
  assign slot_index_o       = os_q;
  assign first_of_section_o = of_q;
  assign last_of_section_o  = ol_q;
  assign status_o           = ost_q;
endmodule

// ===== src/ts_psi_section_reassembler_unit.sv =====
// PSI section reassembler for a packet-aligned transport stream.
// Input channel: queue style, push / full, one stream byte per transaction.
// Output channel: queue style, empty / pop; each transaction is one section
//   byte with slot, first/last marks and a status (verdict on last byte).
// Config: cfg_we_i / cfg_idx_i / cfg_data_i, written only while idle:
//   index 0..2 slot PIDs, index 3 slot enable mask.
// Front: packet counter, header decode, PID match, pointer tracking.
// Back: per-slot length/CRC-32 tracking, one output register.
// A two-entry queue between them decouples the halves.
// Throughput: one byte per cycle sustained while the output is popped;
//   the one-byte-wide CRC XOR network in the back stage sets the cycle.
// A kept byte is written into the queue at its accepting edge, then loaded
//   into the output register when the back stage reads it from the queue.
// While the output is not popped the queue fills and full rises; nothing
//   is dropped. A bad sync byte yields one sync-error transaction and full
//   then stays high until reset.
// Reset (async, active low) clears control and config state; registers
//   read as zero, running CRCs start at all ones; queue and output data are not reset.
module ts_psi_section_reassembler_unit import tsr_pkg::*; #(
  parameter int PacketBytes = PacketBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  ts_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  section_byte_o,
  output logic [1:0]  slot_index_o,
  output logic        first_of_section_o,
  output logic        last_of_section_o,
  output logic [2:0]  status_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [12:0] cfg_data_i
);
`include "ts_psi_section_reassembler_unit_macros.svh"

  logic [12:0] pid0_q, pid1_q, pid2_q;
  logic [2:0]  en_q;
  logic        qwr, qfull, qrd, qvalid;
  work_t       qin, qout;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pid0_q <= '0; pid1_q <= '0; pid2_q <= '0; en_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgSlot0Pid: pid0_q <= cfg_data_i;
        CfgSlot1Pid: pid1_q <= cfg_data_i;
        CfgSlot2Pid: pid2_q <= cfg_data_i;
        CfgSlotEn:   en_q   <= cfg_data_i[2:0];
        default:     ;
      endcase
    end
  end

  tsr_front #(.PacketBytes(PacketBytes)) u_front (
    .clk_i, .rst_ni, .push, .full, .ts_byte_i,
    .pid0_i(pid0_q), .pid1_i(pid1_q), .pid2_i(pid2_q), .en_i(en_q),
    .wr_o(qwr), .wdata_o(qin), .qfull_i(qfull)
  );

  tsr_fifo #(.Depth(2)) u_fifo (
    .clk_i, .rst_ni, .wr_i(qwr), .wdata_i(qin), .full_o(qfull),
    .rd_i(qrd), .valid_o(qvalid), .rdata_o(qout)
  );

  tsr_back u_back (
    .clk_i, .rst_ni, .valid_i(qvalid), .work_i(qout), .rd_o(qrd),
    .empty, .pop, .section_byte_o, .slot_index_o, .first_of_section_o,
    .last_of_section_o, .status_o
  );

  // queue never written while full
  `TSR_ASSERT_IMP(a_no_overflow, qfull, !qwr)
  // a held result stays put while not popped
  `TSR_ASSERT_NXT(a_hold, !empty && !pop, !empty && $stable(section_byte_o))
  // first and last marks never on a sync error
  `TSR_ASSERT_IMP(a_sync_marks, !empty && status_o == StSyncError,
                  !first_of_section_o && !last_of_section_o)
endmodule

// ===== tb/ts_psi_section_reassembler_unit_checker.sv =====
`timescale 1ns / 100ps

module ts_psi_section_reassembler_unit_checker import tsr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  ts_byte_i,
  input  logic        empty,
  input  logic        pop,
  input  logic [7:0]  section_byte_i,
  input  logic [1:0]  slot_index_i,
  input  logic        first_of_section_i,
  input  logic        last_of_section_i,
  input  logic [2:0]  status_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [12:0] cfg_data_i,
  output int          pending_o,
  output int          fails_o
);

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] slot;
    logic       first;
    logic       last;
    status_e    status;
  } section_beat_t;

  section_beat_t awaited_q[$];

  logic [12:0] slot_pid[3];
  logic [2:0]  slot_en;

  logic [7:0]  pkt_pos;
  logic [15:0] hdr;
  logic [7:0]  pay_off;
  logic [7:0]  ptr_left;
  logic        seg_drop;
  logic        halted;
  logic [12:0] sec_cnt[3];
  logic [12:0] sec_len[3];
  logic [31:0] sec_crc[3];

  assign pending_o = awaited_q.size();

  function automatic logic [31:0] crc32_step(logic [31:0] c, logic [7:0] b);
    c = c ^ {b, 24'h0};
    for (int k = 0; k < 8; k++) c = c[31] ? ((c << 1) ^ 32'h04C11DB7) : (c << 1);
    return c;
  endfunction

  task automatic report(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    fails_o++;
  endtask

  task automatic advance_section(input int s, input logic [7:0] b);
    section_beat_t e;
    logic [12:0] c;
    if (seg_drop) return;
    if (sec_cnt[s] == 0 && b == StuffValue) return;
    sec_crc[s] = crc32_step(sec_crc[s], b);
    if (sec_cnt[s] == 1) sec_len[s] = {1'b0, b[3:0], 8'h00};
    else if (sec_cnt[s] == 2)
      sec_len[s] = ((sec_len[s] | {5'd0, b}) & 13'h0fff) + 13'(HeaderBytes);
    e.data = b;
    e.slot = 2'(s);
    e.first = (sec_cnt[s] == 0);
    e.last = 1'b0;
    e.status = StInProgress;
    c = sec_cnt[s] + 13'd1;
    if (c >= HeaderBytes && c == sec_len[s]) begin
      e.last = 1'b1;
      if (c < 4) begin
        e.status = StTooShort;
        seg_drop = 1'b1;
      end else begin
        e.status = (sec_crc[s] == 32'h0) ? StCrcGood : StCrcBad;
      end
      c = '0;
      sec_len[s] = '0;
      sec_crc[s] = '1;
    end
    sec_cnt[s] = c;
    awaited_q.push_back(e);
  endtask

  task automatic absorb_ts_byte(input logic [7:0] b);
    logic [7:0] pos;
    logic [1:0] afc;
    logic [8:0] v;
    int s;
    section_beat_t e;
    if (halted) return;
    pos = pkt_pos;
    pkt_pos = (int'(pos) + 1 >= PacketBytesDef) ? 8'd0 : pos + 8'd1;
    if (pos == 0) begin
      if (b != SyncValue) begin
        halted = 1'b1;
        e = '{data: 8'h0, slot: 2'd0, first: 1'b0, last: 1'b0, status: StSyncError};
        awaited_q.push_back(e);
        return;
      end
      hdr = '0;
      pay_off = NoPayload;
      ptr_left = '0;
      seg_drop = 1'b0;
      return;
    end
    if (pos == 1) begin
      hdr = {b, 8'h00};
      return;
    end
    if (pos == 2) begin
      hdr[7:0] = b;
      return;
    end
    if (pos == 3) begin
      afc = b[5:4];
      pay_off = (afc == 2'd1) ? 8'd4 : (afc == 2'd3) ? 8'd0 : NoPayload;
      return;
    end
    if (pos == 4 && pay_off == 0) begin
      v = 9'd5 + b;
      pay_off = (v > 9'd255) ? NoPayload : v[7:0];
      return;
    end
    if (pay_off == 0 || pos < pay_off) return;
    // lowest enabled slot wins on duplicate PIDs
    s = -1;
    for (int i = 2; i >= 0; i--) if (slot_en[i] && slot_pid[i] == hdr[12:0]) s = i;
    if (s < 0) return;
    if (hdr[14] && pos == pay_off) begin
      ptr_left = b;
      seg_drop = 1'b0;
      return;
    end
    if (ptr_left > 0) begin
      advance_section(s, b);
      ptr_left--;
      if (ptr_left == 0) seg_drop = 1'b0;
    end else begin
      advance_section(s, b);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    section_beat_t e;
    if (!rst_ni) begin
      awaited_q.delete();
      fails_o <= 0;
      slot_pid = '{default: '0};
      slot_en = '0;
      pkt_pos = '0;
      hdr = '0;
      pay_off = '0;
      ptr_left = '0;
      seg_drop = 1'b0;
      halted = 1'b0;
      sec_cnt = '{default: '0};
      sec_len = '{default: '0};
      sec_crc = '{default: '1};
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgSlot0Pid: slot_pid[0] = cfg_data_i;
          CfgSlot1Pid: slot_pid[1] = cfg_data_i;
          CfgSlot2Pid: slot_pid[2] = cfg_data_i;
          CfgSlotEn:   slot_en = cfg_data_i[2:0];
          default: ;
        endcase
      end
      if (pop && !empty) begin
        if (awaited_q.size() == 0) begin
          report($sformatf("unexpected transaction byte %02h", section_byte_i));
        end else begin
          e = awaited_q.pop_front();
          if (section_byte_i !== e.data)
            report($sformatf("section_byte %02h, want %02h", section_byte_i, e.data));
          if (slot_index_i !== e.slot)
            report($sformatf("slot_index %0d, want %0d", slot_index_i, e.slot));
          if (first_of_section_i !== e.first)
            report($sformatf("first_of_section %0b, want %0b", first_of_section_i, e.first));
          if (last_of_section_i !== e.last)
            report($sformatf("last_of_section %0b, want %0b", last_of_section_i, e.last));
          if (status_i !== e.status)
            report($sformatf("status %0d, want %0d", status_i, e.status));
        end
      end
      if (push && !full) absorb_ts_byte(ts_byte_i);
    end
  end

endmodule

// ===== tb/ts_psi_section_reassembler_unit_tb.sv =====
`timescale 1ns / 100ps

module ts_psi_section_reassembler_unit_tb;
  import tsr_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  ts_byte_i = 8'h00;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  section_byte_o;
  logic [1:0]  slot_index_o;
  logic        first_of_section_o;
  logic        last_of_section_o;
  logic [2:0]  status_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = CfgSlot0Pid;
  logic [12:0] cfg_data_i = '0;

  int pending;
  int fails;
  int send_idle;   // percent of cycles the sender holds off
  int recv_stall;  // percent of cycles the consumer refuses a pop

  logic [12:0] cur_pid[3];
  logic [7:0]  pkt[$];
  logic [7:0]  carry[$];   // section bytes that spill into the next packet

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  ts_psi_section_reassembler_unit dut (
    .clk_i, .rst_ni, .push, .full, .ts_byte_i, .empty, .pop,
    .section_byte_o, .slot_index_o, .first_of_section_o, .last_of_section_o,
    .status_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  ts_psi_section_reassembler_unit_checker u_checker (
    .clk_i, .rst_ni, .push, .full, .ts_byte_i, .empty, .pop,
    .section_byte_i(section_byte_o), .slot_index_i(slot_index_o),
    .first_of_section_i(first_of_section_o), .last_of_section_i(last_of_section_o),
    .status_i(status_o), .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .pending_o(pending), .fails_o(fails)
  );

  // Consumer side: random pop, one assignment per edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_stall);
    end
  end

  function automatic logic [31:0] mpeg_crc(logic [31:0] c, logic [7:0] b);
    c = c ^ {b, 24'h0};
    for (int k = 0; k < 8; k++) c = c[31] ? ((c << 1) ^ CrcPoly) : (c << 1);
    return c;
  endfunction

  // One section into carry: table id, 12-bit length, body, CRC (mostly right).
  // Lengths cover zero (too short), tiny, normal and multi-packet.
  task automatic make_section();
    int len;
    int r;
    logic [31:0] c;
    r = $urandom_range(19);
    len = (r == 0) ? 0 : (r == 1) ? $urandom_range(1, 3) :
          (r == 2) ? $urandom_range(200, 600) : $urandom_range(5, 60);
    carry.push_back(8'($urandom_range(254)));
    carry.push_back({4'($urandom), 4'(len >> 8)});
    carry.push_back(8'(len));
    if (len >= 4) begin
      repeat (len - 4) carry.push_back(8'($urandom));
      c = '1;
      foreach (carry[i]) c = mpeg_crc(c, carry[i]);
      if ($urandom_range(9) == 0) c ^= 32'h1 << $urandom_range(31);
      for (int k = 3; k >= 0; k--) carry.push_back(c[8*k +: 8]);
    end else begin
      repeat (len) carry.push_back(8'($urandom));
    end
  endtask

  // Build one 188-byte packet. Mostly a well-formed section stream on a
  // registered PID; sometimes foreign PIDs, no payload, long adaptation
  // fields, pointers past the packet end and stuffing.
  task automatic build_packet();
    logic        pusi;
    logic [12:0] pid;
    logic [1:0]  afc;
    int          r;
    int          al;
    int          ptr;
    pkt.delete();
    pusi = ($urandom_range(9) < 7);
    pid = ($urandom_range(9) < 8) ? cur_pid[$urandom_range(2)] : 13'($urandom);
    r = $urandom_range(19);
    afc = (r == 0) ? 2'd0 : (r == 1) ? 2'd2 : (r < 6) ? 2'd3 : 2'd1;
    pkt.push_back(SyncValue);
    pkt.push_back({1'($urandom), pusi, 1'($urandom), pid[12:8]});
    pkt.push_back(pid[7:0]);
    pkt.push_back({2'($urandom), afc, 4'($urandom)});
    if (afc == 2'd3) begin
      al = ($urandom_range(9) == 0) ? $urandom_range(183, 255) : $urandom_range(20);
      pkt.push_back(8'(al));
      repeat (al) if (pkt.size() < PacketBytesDef) pkt.push_back(8'($urandom));
    end
    if (afc[0] && pkt.size() < PacketBytesDef) begin
      if (pusi) begin
        ptr = ($urandom_range(9) == 0) ? $urandom_range(255) : carry.size();
        pkt.push_back(8'(ptr));
        for (int k = 0; k < ptr && pkt.size() < PacketBytesDef; k++)
          pkt.push_back(carry.size() > 0 ? carry.pop_front() : 8'($urandom));
        carry.delete();
      end
      while (pkt.size() < PacketBytesDef) begin
        if (carry.size() > 0) begin
          pkt.push_back(carry.pop_front());
        end else if ($urandom_range(9) == 0) begin
          while (pkt.size() < PacketBytesDef) pkt.push_back(StuffValue);
        end else begin
          make_section();
        end
      end
    end
    while (pkt.size() < PacketBytesDef) pkt.push_back(8'($urandom));
  endtask

  // Offer one byte; returns in the step where the transaction happened,
  // with push still high so the next byte follows without a bubble.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    ts_byte_i <= b;
    do @(posedge clk_i); while (full);
  endtask

  // Drop push and hold off until every predicted byte has been popped,
  // then let the pipeline settle (the inner queue and the output register).
  task automatic drain();
    push <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [12:0] p0, input logic [12:0] p1,
                           input logic [12:0] p2, input logic [2:0] en,
                           input int idle, input int stall, input int npkt,
                           input bit hold_mid);
    cur_pid = '{p0, p1, p2};
    send_idle = 0;
    recv_stall = 0;
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CfgSlot0Pid; cfg_data_i <= p0;
    @(posedge clk_i);
    cfg_idx_i <= CfgSlot1Pid; cfg_data_i <= p1;
    @(posedge clk_i);
    cfg_idx_i <= CfgSlot2Pid; cfg_data_i <= p2;
    @(posedge clk_i);
    cfg_idx_i <= CfgSlotEn; cfg_data_i <= {10'h0, en};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    send_idle = idle;
    recv_stall = stall;
    for (int n = 0; n < npkt; n++) begin
      build_packet();
      foreach (pkt[i]) send_byte(pkt[i]);
      if (hold_mid && n == 0) drain();
    end
  endtask

  initial begin
    logic [7:0] bad;
    send_idle = 0;
    recv_stall = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // duplicate PID on slots 0/1, extreme PIDs, all slots on
    run_phase(13'h0000, 13'h0000, 13'h1fff, 3'd7, 0, 0, 1, 1'b0);
    run_phase(13'd100, 13'h1fff, 13'h1555, 3'd6, 83, 0, 2, 1'b1);
    run_phase(13'h0aaa, 13'h1555, 13'd100, 3'd3, 0, 83, 2, 1'b0);
    run_phase(13'h1fff, 13'd100, 13'h0000, 3'd7, 29, 29, 1, 1'b0);
    // all slots off: nothing comes out
    run_phase(13'h0000, 13'h0000, 13'h0000, 3'd0, 0, 0, 1, 1'b0);
    drain();
    // bad sync byte last: the block halts for good after it
    bad = 8'($urandom);
    if (bad == SyncValue) bad = 8'h00;
    push <= 1'b1;
    ts_byte_i <= bad;
    do @(posedge clk_i); while (full);
    push <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
